@@ design/bblur_pkg.sv @@
// Shared types and constants for the 3x3 RGB box blur core.
// No dependencies; imported by box_blur_3x3_rgb_core.

package bblur_pkg;

  localparam int CH_W    = 8;               // one color channel
  localparam int PIX_W   = 3 * CH_W;        // packed {red, green, blue}
  localparam int SUM_W   = 12;              // sum of nine channel values
  localparam int WIDTH_W  = 11;             // image_width register
  localparam int HEIGHT_W = 13;             // image_height register
  localparam int CFG_W    = 13;             // widest register
  localparam int ROW_W    = 12;             // output row counter
  localparam int MAX_HEIGHT = 4096;
  localparam int DEF_MAX_WIDTH = 1024;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 11'd512;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 13'd512;

  // Floor division by nine for sums up to 2295: (s * 7282) >> 16.
  localparam int DIV9_MULT  = 7282;
  localparam int DIV9_SHIFT = 16;
  localparam int PROD_W     = 25;

  // Configuration register indexes.
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0]   pix_t;
  typedef logic [2*PIX_W-1:0] pair_t;     // {upper line, middle line}
  typedef logic [SUM_W-1:0]   sum_t;

endpackage

@@ design/box_blur_3x3_rgb_core.sv @@
// Streaming 3x3 box blur on RGB pixels in raster order.
// Depends on bblur_pkg for widths, the divide-by-nine constants and types.

// The core takes one word per clock on the input stream: a pixel (tuser low) or a drain
// word (tuser high) that flushes pending results after the frame. Each result word is the
// pixel one line plus one pixel earlier in raster order; interior pixels get the floor of the
// nine-pixel channel sums divided by nine, pixels on the first and last rows and columns pass
// through unchanged, and tlast marks the last pixel of the frame. The sustained rate is one
// word per clock while out_tready is not holding the stream, set by the single read and
// single write per cycle of the line memory; a word moves through four register stages
// (accept and memory read, window shift and memory write, channel sums, divide and output
// register). Drain words with nothing pending are consumed silently. Writing either
// configuration register restarts the frame position; the line memory needs no clearing
// pass, since unwritten entries only ever reach border pixels.

module box_blur_3x3_rgb_core
  import bblur_pkg::*;
#(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  // Input stream.
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [PIX_W-1:0]    in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic                in_tuser,   // drain
  // Result stream.
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [PIX_W-1:0]    out_tdata,  // red [7:0], green [15:8], blue [23:16]
  output logic                out_tlast,  // frame_end
  // Configuration write port.
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [CFG_W-1:0]    cfg_wdata
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int PW    = $clog2(MAX_WIDTH + 2);
  localparam int MAXA  = (CW > PW) ? CW : PW;
  localparam int CMP_W = ((MAXA > WIDTH_W) ? MAXA : WIDTH_W) + 1;

  // Configuration registers and the sizes in use.
  logic [WIDTH_W-1:0]  image_width_r;
  logic [HEIGHT_W-1:0] image_height_r;
  logic [CMP_W-1:0]    w_used;
  logic [HEIGHT_W-1:0] h_used;

  always_comb begin
    if (image_width_r == '0) begin
      w_used = CMP_W'(1);
    end else if (CMP_W'(image_width_r) > CMP_W'(MAX_WIDTH)) begin
      w_used = CMP_W'(MAX_WIDTH);
    end else begin
      w_used = CMP_W'(image_width_r);
    end
    if (image_height_r == '0) begin
      h_used = HEIGHT_W'(1);
    end else if (image_height_r > HEIGHT_W'(MAX_HEIGHT)) begin
      h_used = HEIGHT_W'(MAX_HEIGHT);
    end else begin
      h_used = image_height_r;
    end
  end

  // Position counters.
  logic [CW-1:0]    in_col_r,  in_col_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [PW-1:0]    pend_r,    pend_nxt;

  // Pipeline handshake.
  logic v1_r, v2_r, v3_r, out_v_r;
  logic s1_fire, s2_fire, s3_fire;
  logic s2_rdy, s3_rdy, s4_rdy;
  logic in_acc, item_go;

  assign s4_rdy  = !out_v_r || out_tready;
  assign s3_rdy  = !v3_r || s4_rdy;
  assign s3_fire = v3_r && s4_rdy;
  assign s2_rdy  = !v2_r || s3_rdy;
  assign s2_fire = v2_r && s3_rdy;
  assign s1_fire = v1_r && s2_rdy;
  assign in_tready = !v1_r || s2_rdy;
  assign in_acc  = in_tvalid && in_tready;
  // A drain word with nothing pending changes nothing.
  assign item_go = in_acc && !(in_tuser && (pend_r == '0));

  // Decisions made at accept time from the counters.
  logic emit, border, frame_end;
  logic last_col, last_row;
  logic [CMP_W-1:0] in_col_inc, out_col_inc;

  always_comb begin
    in_col_inc  = CMP_W'(in_col_r) + CMP_W'(1);
    out_col_inc = CMP_W'(out_col_r) + CMP_W'(1);
    last_col    = out_col_inc >= w_used;
    last_row    = (HEIGHT_W'(out_row_r) + HEIGHT_W'(1)) >= h_used;
    border      = (out_row_r == '0) || last_row || (out_col_r == '0) || last_col;
    frame_end   = last_row && last_col;
    emit        = in_tuser || (CMP_W'(pend_r) >= (w_used + CMP_W'(1)));

    in_col_nxt  = in_col_r;
    out_col_nxt = out_col_r;
    out_row_nxt = out_row_r;
    pend_nxt    = pend_r;
    if (item_go) begin
      in_col_nxt = (in_col_inc >= w_used) ? '0 : in_col_inc[CW-1:0];
      if (emit) begin
        if (last_col) begin
          out_col_nxt = '0;
          out_row_nxt = last_row ? '0 : out_row_r + ROW_W'(1);
        end else begin
          out_col_nxt = out_col_inc[CW-1:0];
        end
      end
      if (in_tuser) begin
        pend_nxt = pend_r - PW'(1);
        // The last drain closes the frame: both positions go back to the origin.
        if (pend_r == PW'(1)) begin
          in_col_nxt  = '0;
          out_col_nxt = '0;
          out_row_nxt = '0;
        end
      end else if (!emit) begin
        pend_nxt = pend_r + PW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= WIDTH_RST;
      image_height_r <= HEIGHT_RST;
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r  <= cfg_wdata[WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r <= cfg_wdata;
        default: ;
      endcase
      in_col_r  <= '0;
      out_col_r <= '0;
      out_row_r <= '0;
      pend_r    <= '0;
    end else begin
      in_col_r  <= in_col_nxt;
      out_col_r <= out_col_nxt;
      out_row_r <= out_row_nxt;
      pend_r    <= pend_nxt;
    end
  end

  // Stage 1: accepted word and the line memory read at its column.
  pix_t          s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  logic          s1_emit_r, s1_border_r, s1_fe_r;
  pair_t         rd_r;
  pair_t         line_mem [MAX_WIDTH];
  pair_t         wr_data;

  assign wr_data = {rd_r[PIX_W-1:0], s1_pix_r};

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      line_mem[s1_addr_r] <= wr_data;
    end
    if (item_go) begin
      // The word leaving stage 1 writes this edge; forward it on a same-column read.
      if (s1_fire && (s1_addr_r == in_col_r)) begin
        rd_r <= wr_data;
      end else begin
        rd_r <= line_mem[in_col_r];
      end
      s1_pix_r    <= in_tuser ? '0 : {in_tdata[CH_W-1:0], in_tdata[2*CH_W-1:CH_W],
                                      in_tdata[PIX_W-1:2*CH_W]};
      s1_addr_r   <= in_col_r;
      s1_emit_r   <= emit;
      s1_border_r <= border;
      s1_fe_r     <= frame_end;
    end
  end

  // Stage 2: the 3x3 window, shifted one column per word.
  pix_t win_r [9];
  logic s2_border_r, s2_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) begin
        win_r[i] <= '0;
      end
    end else if (s1_fire) begin
      for (int r = 0; r < 3; r++) begin
        win_r[r*3]     <= win_r[r*3+1];
        win_r[r*3+1]   <= win_r[r*3+2];
      end
      win_r[2] <= rd_r[2*PIX_W-1:PIX_W];
      win_r[5] <= rd_r[PIX_W-1:0];
      win_r[8] <= s1_pix_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      s2_border_r <= s1_border_r;
      s2_fe_r     <= s1_fe_r;
    end
  end

  // Stage 3: channel sums over the window, plus the center pixel for borders.
  sum_t sum_nxt [3];
  sum_t sum_r   [3];
  pix_t center_r;
  logic s3_border_r, s3_fe_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_nxt[c] = '0;
      for (int i = 0; i < 9; i++) begin
        sum_nxt[c] = sum_nxt[c] + SUM_W'(win_r[i][PIX_W-1-c*CH_W -: CH_W]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      for (int c = 0; c < 3; c++) begin
        sum_r[c] <= sum_nxt[c];
      end
      center_r    <= win_r[4];
      s3_border_r <= s2_border_r;
      s3_fe_r     <= s2_fe_r;
    end
  end

  // Stage 4: divide by nine and the output register.
  logic [PROD_W-1:0] prod [3];
  logic [CH_W-1:0]   chan [3];
  logic [PIX_W-1:0]  out_data_r;
  logic              out_last_r;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = PROD_W'(sum_r[c]) * PROD_W'(DIV9_MULT);
      chan[c] = s3_border_r ? center_r[PIX_W-1-c*CH_W -: CH_W]
                            : prod[c][DIV9_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk) begin
    if (s3_fire) begin
      out_data_r <= {chan[2], chan[1], chan[0]};
      out_last_r <= s3_fe_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (item_go) begin
        v1_r <= 1'b1;
      end else if (s1_fire) begin
        v1_r <= 1'b0;
      end
      if (s1_fire) begin
        v2_r <= s1_emit_r;
      end else if (s2_fire) begin
        v2_r <= 1'b0;
      end
      if (s2_fire) begin
        v3_r <= 1'b1;
      end else if (s3_fire) begin
        v3_r <= 1'b0;
      end
      if (s3_fire) begin
        out_v_r <= 1'b1;
      end else if (out_tready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  // Pending results never exceed one line plus one pixel.
  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(pend_r) <= (w_used + CMP_W'(1)))
    else $error("pending count above one line plus one pixel");

  // The write column always lies inside the line in use.
  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(in_col_r) < w_used)
    else $error("input column outside the line");

  // The output row always lies inside the frame in use.
  a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (HEIGHT_W'(out_row_r) < h_used) && (CMP_W'(out_col_r) < w_used))
    else $error("output position outside the frame");

  // A register write restarts the frame.
  a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (pend_r == '0) && (in_col_r == '0) && (out_row_r == '0))
    else $error("frame position not cleared by a register write");

  // An empty accept stage always takes a word.
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !v1_r |-> in_tready)
    else $error("input stalled with an empty accept stage");

endmodule
